// ===== design/text_buffer_with_cursor_clipboard_core_assert.svh =====
// assertion macros for the text buffer core
`ifndef TEXT_BUFFER_WITH_CURSOR_CLIPBOARD_CORE_ASSERT_SVH
`define TEXT_BUFFER_WITH_CURSOR_CLIPBOARD_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// property checked on every clock edge outside reset
`define TBC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// condition in one cycle implies a result in the next
`define TBC_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define TBC_ASSERT(lbl, prop, msg)
`define TBC_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

// ===== design/tbc_pkg.sv =====
`default_nettype none

package tbc_pkg;

    // command codes
    localparam logic [2:0] CMD_LEFT   = 3'd0;
    localparam logic [2:0] CMD_RIGHT  = 3'd1;
    localparam logic [2:0] CMD_INSERT = 3'd2;
    localparam logic [2:0] CMD_CUT    = 3'd3;
    localparam logic [2:0] CMD_COPY   = 3'd4;
    localparam logic [2:0] CMD_PASTE  = 3'd5;
    localparam logic [2:0] CMD_READ   = 3'd6;

    // input word
    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] ch;
        logic [8:0] count;
        logic [7:0] index;
    } t_in_word;

    // result word
    typedef struct packed {
        logic [8:0] text_length;
        logic [8:0] cursor;
        logic [7:0] read_char;
        logic       read_valid;
        logic [8:0] clip_length;
        logic       overflow;
    } t_out_word;

endpackage

`default_nettype wire

// ===== design/tbc_stream_if.sv =====
`default_nettype none

interface tbc_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/text_buffer_with_cursor_clipboard_core.sv =====
`default_nettype none
`include "text_buffer_with_cursor_clipboard_core_assert.svh"

// Text buffer with cursor and clipboard. One command word in, one status word out. The text and
// the clipboard sit in two single-port-read memories of TEXT_CAPACITY bytes; every character
// move goes through one read per cycle with the write in the cycle after it, stepped by a single
// shared address/count unit. Each accepted command passes through a decode state and, for left,
// right, read and the unused code, straight on to a done state, where the result word is
// registered. Insert shifts the tail up and then puts the character, or only flags overflow
// when the text is full; cut copies the taken bytes to the clipboard and then closes the gap;
// copy only fills the clipboard; paste shifts the tail up and then fills in from the clipboard.
// The input side is ready only between commands, and a finished result waits in an output
// register while the next command is taken; a result that is still not taken when the next one
// finishes holds the block until it is. No clearing pass runs after reset.
module text_buffer_with_cursor_clipboard_core #(
    parameter int TEXT_CAPACITY = 256
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    tbc_stream_if.sink    i_in,
    tbc_stream_if.source  o_out
);
    import tbc_pkg::*;

    localparam int AW = $clog2(TEXT_CAPACITY);
    localparam int CW = $clog2(TEXT_CAPACITY + 1);
    localparam int XW = (CW > 9) ? CW : 9;
    localparam logic [CW-1:0] CAP = CW'(TEXT_CAPACITY);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECODE = 7'b0000010,
        S_CLIP   = 7'b0000100,
        S_SHIFT  = 7'b0001000,
        S_FILL   = 7'b0010000,
        S_PUT    = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    t_state          r_state, n_state;
    logic [2:0]      r_cmd, n_cmd;
    logic [7:0]      r_ch, n_ch;
    logic [8:0]      r_count, n_count;
    logic [7:0]      r_idx, n_idx;
    logic [CW-1:0]   r_tcnt, n_tcnt;
    logic [CW-1:0]   r_cur, n_cur;
    logic [CW-1:0]   r_ccnt, n_ccnt;
    logic [CW-1:0]   r_n, n_n;
    logic [CW-1:0]   r_rem, n_rem;
    logic [AW-1:0]   r_src, n_src;
    logic [AW-1:0]   r_dst, n_dst;
    logic            r_down, n_down;
    logic            r_ovf, n_ovf;
    logic            r_rvalid, n_rvalid;
    logic            r_wp, n_wp;
    logic [AW-1:0]   r_wa, n_wa;
    logic            r_wclip, n_wclip;
    logic            r_wfrom_clip, n_wfrom_clip;
    logic            r_ovalid, n_ovalid;
    t_out_word       r_out, n_out;

    logic [7:0]      text_mem [TEXT_CAPACITY];
    logic [7:0]      clip_mem [TEXT_CAPACITY];
    logic [7:0]      r_text_q;
    logic [7:0]      r_clip_q;

    t_in_word        in_w;
    logic            in_acc;
    logic [XW-1:0]   tc_x, cp_x, cc_x, cnt_x, idx_x;
    logic [CW-1:0]   avail, take, room, pn;
    logic            paste_short;
    logic            step;
    logic [AW-1:0]   text_raddr;
    logic            text_we;
    logic [AW-1:0]   text_wa;
    logic [7:0]      text_wd;
    logic            clip_we;

    assign in_w   = i_in.data;
    assign in_acc = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_out;

    // widened views for compares against the input fields
    assign tc_x  = XW'(r_tcnt);
    assign cp_x  = XW'(r_cur);
    assign cc_x  = XW'(r_ccnt);
    assign cnt_x = XW'(r_count);
    assign idx_x = XW'(r_idx);

    // command bounds
    assign avail       = r_tcnt - r_cur;
    assign take        = (cnt_x < XW'(avail)) ? CW'(r_count) : avail;
    assign room        = CAP - r_tcnt;
    assign paste_short = (r_ccnt > room);
    assign pn          = paste_short ? room : r_ccnt;

    // one character moves per cycle while a count remains
    assign step = ((r_state == S_CLIP) || (r_state == S_SHIFT) || (r_state == S_FILL))
                  && (r_rem != '0);

    // memory ports
    assign text_raddr = ((r_state == S_CLIP) || (r_state == S_SHIFT)) ? r_src : AW'(r_idx);
    assign text_we    = (r_wp && !r_wclip) || (r_state == S_PUT);
    assign text_wa    = (r_state == S_PUT) ? AW'(r_cur) : r_wa;
    assign text_wd    = (r_state == S_PUT) ? r_ch : (r_wfrom_clip ? r_clip_q : r_text_q);
    assign clip_we    = r_wp && r_wclip;

    always_ff @(posedge i_clk) begin
        if (text_we) begin
            text_mem[text_wa] <= text_wd;
        end
        r_text_q <= text_mem[text_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (clip_we) begin
            clip_mem[r_wa] <= r_text_q;
        end
        r_clip_q <= clip_mem[r_src];
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_ch         = r_ch;
        n_count      = r_count;
        n_idx        = r_idx;
        n_tcnt       = r_tcnt;
        n_cur        = r_cur;
        n_ccnt       = r_ccnt;
        n_n          = r_n;
        n_rem        = r_rem;
        n_src        = r_src;
        n_dst        = r_dst;
        n_down       = r_down;
        n_ovf        = r_ovf;
        n_rvalid     = r_rvalid;
        n_wp         = 1'b0;
        n_wa         = r_wa;
        n_wclip      = r_wclip;
        n_wfrom_clip = r_wfrom_clip;
        n_ovalid     = r_ovalid;
        n_out        = r_out;

        // drop the result word once taken
        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end

        // shared address and count stepping
        if (step) begin
            n_wp         = 1'b1;
            n_wa         = r_dst;
            n_wclip      = (r_state == S_CLIP);
            n_wfrom_clip = (r_state == S_FILL);
            n_src        = r_down ? r_src - AW'(1) : r_src + AW'(1);
            n_dst        = r_down ? r_dst - AW'(1) : r_dst + AW'(1);
            n_rem        = r_rem - CW'(1);
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_cmd   = in_w.cmd;
                    n_ch    = in_w.ch;
                    n_count = in_w.count;
                    n_idx   = in_w.index;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_ovf    = 1'b0;
                n_rvalid = 1'b0;
                n_state  = S_DONE;
                unique case (r_cmd) inside
                    CMD_LEFT: begin
                        if (r_cur != '0) begin
                            n_cur = r_cur - CW'(1);
                        end
                    end
                    CMD_RIGHT: begin
                        if (r_cur < r_tcnt) begin
                            n_cur = r_cur + CW'(1);
                        end
                    end
                    CMD_INSERT: begin
                        if (r_tcnt == CAP) begin
                            n_ovf = 1'b1;
                        end else begin
                            n_rem   = avail;
                            n_src   = AW'(r_tcnt - CW'(1));
                            n_dst   = AW'(r_tcnt);
                            n_down  = 1'b1;
                            n_state = S_SHIFT;
                        end
                    end
                    CMD_CUT, CMD_COPY: begin
                        n_ccnt  = take;
                        n_n     = take;
                        n_rem   = take;
                        n_src   = AW'(r_cur);
                        n_dst   = '0;
                        n_down  = 1'b0;
                        n_state = S_CLIP;
                    end
                    CMD_PASTE: begin
                        n_ovf   = paste_short;
                        n_n     = pn;
                        n_rem   = (pn == '0) ? '0 : avail;
                        n_src   = AW'(r_tcnt - CW'(1));
                        n_dst   = AW'(r_tcnt - CW'(1) + pn);
                        n_down  = 1'b1;
                        n_state = S_SHIFT;
                    end
                    CMD_READ: begin
                        n_rvalid = (idx_x < tc_x);
                    end
                    default: begin
                    end
                endcase
            end
            S_CLIP: begin
                if (!step) begin
                    if (r_cmd == CMD_CUT) begin
                        // close the gap behind the cut
                        n_rem   = (r_n == '0) ? '0 : r_tcnt - r_cur - r_n;
                        n_src   = AW'(r_cur + r_n);
                        n_dst   = AW'(r_cur);
                        n_down  = 1'b0;
                        n_state = S_SHIFT;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SHIFT: begin
                if (!step) begin
                    case (r_cmd)
                        CMD_INSERT: begin
                            n_state = S_PUT;
                        end
                        CMD_PASTE: begin
                            n_rem   = r_n;
                            n_src   = '0;
                            n_dst   = AW'(r_cur);
                            n_down  = 1'b0;
                            n_state = S_FILL;
                        end
                        default: begin
                            n_tcnt  = r_tcnt - r_n;
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_FILL: begin
                if (!step) begin
                    n_tcnt  = r_tcnt + r_n;
                    n_cur   = r_cur + r_n;
                    n_state = S_DONE;
                end
            end
            S_PUT: begin
                n_tcnt  = r_tcnt + CW'(1);
                n_cur   = r_cur + CW'(1);
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || o_out.ready) begin
                    n_out.text_length = tc_x[8:0];
                    n_out.cursor      = cp_x[8:0];
                    n_out.read_char   = r_rvalid ? r_text_q : 8'd0;
                    n_out.read_valid  = r_rvalid;
                    n_out.clip_length = cc_x[8:0];
                    n_out.overflow    = r_ovf;
                    n_ovalid          = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_tcnt   <= '0;
            r_cur    <= '0;
            r_ccnt   <= '0;
            r_ovalid <= 1'b0;
            r_wp     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_tcnt   <= n_tcnt;
            r_cur    <= n_cur;
            r_ccnt   <= n_ccnt;
            r_ovalid <= n_ovalid;
            r_wp     <= n_wp;
        end
    end

    // command fields, move registers and result word
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_ch         <= n_ch;
        r_count      <= n_count;
        r_idx        <= n_idx;
        r_n          <= n_n;
        r_rem        <= n_rem;
        r_src        <= n_src;
        r_dst        <= n_dst;
        r_down       <= n_down;
        r_ovf        <= n_ovf;
        r_rvalid     <= n_rvalid;
        r_wa         <= n_wa;
        r_wclip      <= n_wclip;
        r_wfrom_clip <= n_wfrom_clip;
        r_out        <= n_out;
    end

    // checks
    `TBC_ASSERT(a_cur_in_text, r_cur <= r_tcnt, "cursor past end of text")
    `TBC_ASSERT(a_text_bound, (r_tcnt <= CAP) && (r_ccnt <= CAP), "count above capacity")
    `TBC_ASSERT(a_put_no_pend, (r_state == S_PUT) |-> !r_wp, "two text writes in one cycle")
    `TBC_ASSERT_NEXT(a_fill_end, (r_state == S_FILL) && (r_rem == '0),
        r_tcnt == $past(r_tcnt) + $past(r_n), "paste length not added")

endmodule

`default_nettype wire
